// ===== sv/nm3_pkg.sv =====
// Shared types and constants for the 3x3 neighbor mean filter.
// No dependencies; used by the filter top level and its port checker.
package nm3_pkg;

  localparam int MAX_ROW_ELEMENTS = 2048;
  localparam int MAX_ROWS         = 2048;
  localparam int MIN_SIZE         = 3;

  localparam int COL_W = $clog2(MAX_ROW_ELEMENTS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CFG_W = 12;
  localparam int PIX_W = 8;
  localparam int SUM_W = PIX_W + 3;

  // Output queue between the compute stage and the result port.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic CFG_ROW_ELEMENTS = 1'b0;
  localparam logic CFG_FRAME_ROWS   = 1'b1;

  localparam logic [CFG_W-1:0] ROW_ELEMENTS_RESET = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_ROWS_RESET   = 12'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic             command;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

endpackage

// ===== sv/neighbor_mean_3x3_filter.sv =====
// 3x3 neighbor mean filter top level: line store memory, window, output queue.
// Depends on nm3_pkg for types and sizes.
//
// The block takes one byte element per cycle in raster order and returns, one row and one
// element behind, the mean of the eight neighbors of each interior element (sum divided by
// eight, rounded to nearest, ties to even); border elements come out as zero. Every transfer
// in yields at most two results: the last element of a row also releases the zero at the
// end of the output row, so with a free-running result port the input pauses once per
// row, and otherwise an element is taken every cycle. The first result of an input
// transfer is registered in the compute stage and then written into the output queue,
// from which it is offered. The two previous rows live in one 2048 x 16 simple dual-port
// memory (read when an element is taken, written back in the following cycle), which sets
// the maximum row length. After the last row is in, drain commands emit the all-zero last
// output row, one element per command; pixel transfers in that phase are dropped. The line
// memory is not cleared after reset and needs no clearing pass.
module neighbor_mean_3x3_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nm3_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nm3_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [nm3_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int COL_W = nm3_pkg::COL_W;
  localparam int ROW_W = nm3_pkg::ROW_W;
  localparam int CFG_W = nm3_pkg::CFG_W;
  localparam int PIX_W = nm3_pkg::PIX_W;
  localparam int SUM_W = nm3_pkg::SUM_W;
  localparam int PTR_W = nm3_pkg::FIFO_PTR_W;
  localparam int CNT_W = nm3_pkg::FIFO_CNT_W;

  typedef struct packed {
    logic             valid;
    logic             wr;        // pixel stored: update window and line memory
    logic             emit_a;    // first result (mean or drain zero)
    logic             emit_b;    // end-of-row zero
    logic             interior;
    logic             a_end;     // drain result closes the frame
    logic [COL_W-1:0] idx;
    logic [PIX_W-1:0] pixel;
  } s1_t;

  // Configuration registers.
  logic [CFG_W-1:0] row_elements_r;
  logic [CFG_W-1:0] frame_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_elements_r <= nm3_pkg::ROW_ELEMENTS_RESET;
      frame_rows_r   <= nm3_pkg::FRAME_ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nm3_pkg::CFG_ROW_ELEMENTS: row_elements_r <= cfg_wdata;
        nm3_pkg::CFG_FRAME_ROWS:   frame_rows_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped sizes as last indexes.
  logic [CFG_W-1:0] w_clamp, h_clamp;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  always_comb begin
    if (row_elements_r < CFG_W'(nm3_pkg::MIN_SIZE)) begin
      w_clamp = CFG_W'(nm3_pkg::MIN_SIZE);
    end else if (32'(row_elements_r) > 32'(nm3_pkg::MAX_ROW_ELEMENTS)) begin
      w_clamp = CFG_W'(nm3_pkg::MAX_ROW_ELEMENTS);
    end else begin
      w_clamp = row_elements_r;
    end
    if (frame_rows_r < CFG_W'(nm3_pkg::MIN_SIZE)) begin
      h_clamp = CFG_W'(nm3_pkg::MIN_SIZE);
    end else if (32'(frame_rows_r) > 32'(nm3_pkg::MAX_ROWS)) begin
      h_clamp = CFG_W'(nm3_pkg::MAX_ROWS);
    end else begin
      h_clamp = frame_rows_r;
    end
    w_last = COL_W'(w_clamp - CFG_W'(1));
    h_last = ROW_W'(h_clamp - CFG_W'(1));
  end

  // Stream position.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] drain_cnt_r, drain_cnt_nxt;
  logic             drain_pend_r, drain_pend_nxt;

  s1_t  s1_r, s1_nxt;
  logic accept;
  logic pixel_ok, drain_ok, col_last, drain_last;

  // Output queue.
  nm3_pkg::out_item_t fifo_r [nm3_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   head_r, tail_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [1:0]         s1_n;
  logic               pop;

  assign s1_n = s1_r.valid ? ({1'b0, s1_r.emit_a} + {1'b0, s1_r.emit_b}) : 2'd0;

  // Room is held for whatever the item in the compute stage pushes plus two more.
  assign in_ready = ({1'b0, cnt_r} + {{(CNT_W - 1){1'b0}}, s1_n})
                    <= (CNT_W + 1)'(nm3_pkg::FIFO_DEPTH - 2);
  assign accept   = in_valid && in_ready;

  always_comb begin
    pixel_ok   = (in_data.command == nm3_pkg::CMD_PIXEL) && !drain_pend_r;
    drain_ok   = (in_data.command == nm3_pkg::CMD_DRAIN) && drain_pend_r;
    col_last   = col_r >= w_last;
    drain_last = drain_cnt_r >= w_last;

    col_nxt        = col_r;
    row_nxt        = row_r;
    drain_cnt_nxt  = drain_cnt_r;
    drain_pend_nxt = drain_pend_r;

    if (accept && drain_ok) begin
      if (drain_last) begin
        drain_pend_nxt = 1'b0;
        drain_cnt_nxt  = '0;
      end else begin
        drain_cnt_nxt = drain_cnt_r + COL_W'(1);
      end
    end else if (accept && pixel_ok) begin
      if (col_last) begin
        col_nxt = '0;
        if (row_r >= h_last) begin
          row_nxt        = '0;
          drain_pend_nxt = 1'b1;
          drain_cnt_nxt  = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    s1_nxt.valid    = accept;
    s1_nxt.wr       = pixel_ok;
    s1_nxt.emit_a   = drain_ok || (pixel_ok && (row_r != '0) && (col_r != '0));
    s1_nxt.emit_b   = pixel_ok && col_last && (row_r != '0);
    s1_nxt.interior = pixel_ok && (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2))
                      && (col_r <= w_last);
    s1_nxt.a_end    = drain_ok && drain_last;
    s1_nxt.idx      = col_r;
    s1_nxt.pixel    = in_data.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      drain_cnt_r  <= '0;
      drain_pend_r <= 1'b0;
      s1_r         <= '0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      drain_cnt_r  <= drain_cnt_nxt;
      drain_pend_r <= drain_pend_nxt;
      s1_r         <= s1_nxt;
    end
  end

  // Line memory: [15:8] holds the row two back, [7:0] the row one back.
  logic [2*PIX_W-1:0] line_mem [nm3_pkg::MAX_ROW_ELEMENTS];
  logic [2*PIX_W-1:0] line_rdata_r;
  logic [PIX_W-1:0]   top, mid, bot;

  always_ff @(posedge clk) begin
    if (accept) begin
      line_rdata_r <= line_mem[col_r];
    end
    if (s1_r.valid && s1_r.wr) begin
      line_mem[s1_r.idx] <= {mid, bot};
    end
  end

  assign top = line_rdata_r[2*PIX_W-1:PIX_W];
  assign mid = line_rdata_r[PIX_W-1:0];
  assign bot = s1_r.pixel;

  // Window: index row*2 + col, col 0 two elements back, col 1 one element back.
  logic [PIX_W-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_r.valid && s1_r.wr) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top;
      win_r[2] <= win_r[3];
      win_r[3] <= mid;
      win_r[4] <= win_r[5];
      win_r[5] <= bot;
    end
  end

  // Neighbor sum without the center, then divide by eight with round half to even.
  logic [SUM_W-1:0]   sum;
  logic [PIX_W-1:0]   quot, mean;
  logic [2:0]         frac;
  nm3_pkg::out_item_t res_a, res_b;

  always_comb begin
    sum = SUM_W'(win_r[0]) + SUM_W'(win_r[2]) + SUM_W'(win_r[4])
        + SUM_W'(win_r[1]) + SUM_W'(win_r[5])
        + SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
    quot = sum[SUM_W-1:3];
    frac = sum[2:0];
    if ((frac > 3'd4) || ((frac == 3'd4) && quot[0])) begin
      mean = quot + PIX_W'(1);
    end else begin
      mean = quot;
    end

    res_a.pixel_out = s1_r.interior ? mean : '0;
    res_a.row_end   = s1_r.a_end;
    res_a.frame_end = s1_r.a_end;
    res_b.pixel_out = '0;
    res_b.row_end   = 1'b1;
    res_b.frame_end = 1'b0;
  end

  // Output queue; the end-of-row zero goes in behind the mean of the same transfer.
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[head_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s1_r.valid && s1_r.emit_a) begin
      fifo_r[tail_r] <= res_a;
    end
    if (s1_r.valid && s1_r.emit_b) begin
      fifo_r[tail_r + PTR_W'(s1_r.emit_a)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_r + PTR_W'(pop);
      tail_r <= tail_r + PTR_W'(s1_n);
      cnt_r  <= cnt_r + CNT_W'(s1_n) - CNT_W'(pop);
    end
  end

endmodule

// ===== sv/nm3_chk.sv =====
// Port-level checker for the 3x3 neighbor mean filter, bound to the top level.
// Depends on nm3_pkg for the payload types.
module nm3_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input nm3_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input nm3_pkg::out_item_t out_data
);

  // An input item that is not taken stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed or withdrawn before transfer");

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or withdrawn before transfer");

  // Every row end, including the frame end, is a border element and reads zero.
  a_row_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.pixel_out == '0)
    else $error("row end result is not zero");

  // The frame end is always also a row end.
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.row_end)
    else $error("frame end without row end");

  // Reset empties the output queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind neighbor_mean_3x3_filter nm3_chk u_nm3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/neighbor_mean_3x3_checker.sv =====
// Result checker for the 3x3 neighbor mean filter: predicts every output transfer
// from the observed input and register writes and compares it with the result port.
// Depends on nm3_pkg for the payload types, register indexes and sizes.
`timescale 1ns / 1ps

module neighbor_mean_3x3_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  nm3_pkg::in_item_t     in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  nm3_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [nm3_pkg::CFG_W-1:0] cfg_wdata,
  output int                    awaited_count,
  output int                    mismatch_count
);
  import nm3_pkg::*;

  logic [PIX_W-1:0] row_above2 [MAX_ROW_ELEMENTS];
  logic [PIX_W-1:0] row_above1 [MAX_ROW_ELEMENTS];
  // Two older window columns per row: index row*2 + col, col 0 is two elements back.
  logic [PIX_W-1:0] win [6];
  int               col_pos;
  int               row_pos;
  int               drain_pos;
  bit               draining;
  logic [CFG_W-1:0] row_len_reg;
  logic [CFG_W-1:0] frame_rows_reg;
  out_item_t        pending_results [$];
  int               mismatches = 0;

  function automatic int fit_size(input logic [CFG_W-1:0] raw, input int hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic out_item_t make_result(input logic [PIX_W-1:0] px, input logic re,
                                            input logic fe);
    out_item_t o;
    o.pixel_out = px;
    o.row_end   = re;
    o.frame_end = fe;
    return o;
  endfunction

  task automatic filter_element(input in_item_t item);
    int w, h, c, r, idx, sum, mean;
    logic [PIX_W-1:0] up2, up1, cur;
    bit at_end;
    w = fit_size(row_len_reg, MAX_ROW_ELEMENTS);
    h = fit_size(frame_rows_reg, MAX_ROWS);
    if (item.command == CMD_DRAIN) begin
      // Drains before the last row is complete are dropped without a result.
      if (draining) begin
        if (drain_pos >= w - 1) begin
          pending_results.push_back(make_result('0, 1'b1, 1'b1));
          draining  = 1'b0;
          drain_pos = 0;
        end else begin
          pending_results.push_back(make_result('0, 1'b0, 1'b0));
          drain_pos++;
        end
      end
    end else if (!draining) begin
      c      = col_pos;
      r      = row_pos;
      idx    = (c < MAX_ROW_ELEMENTS) ? c : MAX_ROW_ELEMENTS - 1;
      up2    = row_above2[idx];
      up1    = row_above1[idx];
      cur    = item.pixel_in;
      at_end = (c >= w - 1);
      if (r >= 1 && c >= 1) begin
        mean = 0;
        if (r >= 2 && c >= 2 && c < w) begin
          sum  = win[0] + win[1] + win[2] + win[4] + win[5] + up2 + up1 + cur;
          mean = sum >> 3;
          if ((sum % 8) > 4 || ((sum % 8) == 4 && (mean % 2) == 1))
            mean++;
        end
        pending_results.push_back(make_result(PIX_W'(mean), 1'b0, 1'b0));
      end
      // The last element also releases the zero at the end of the output row.
      if (at_end && r >= 1)
        pending_results.push_back(make_result('0, 1'b1, 1'b0));
      win[0] = win[1];
      win[1] = up2;
      win[2] = win[3];
      win[3] = up1;
      win[4] = win[5];
      win[5] = cur;
      row_above2[idx] = up1;
      row_above1[idx] = cur;
      if (at_end) begin
        col_pos = 0;
        if (r + 1 >= h) begin
          row_pos   = 0;
          draining  = 1'b1;
          drain_pos = 0;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROW_ELEMENTS; i++) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      for (int i = 0; i < 6; i++)
        win[i] = '0;
      col_pos        = 0;
      row_pos        = 0;
      drain_pos      = 0;
      draining       = 1'b0;
      row_len_reg    = ROW_ELEMENTS_RESET;
      frame_rows_reg = FRAME_ROWS_RESET;
      pending_results.delete();
    end else begin
      // An input transfer sees the sizes in force before a write at the same edge.
      if (in_valid && in_ready)
        filter_element(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_ELEMENTS: row_len_reg = cfg_wdata;
          CFG_FRAME_ROWS:   frame_rows_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result: pixel %0d row_end %0b frame_end %0b",
                                  out_data.pixel_out, out_data.row_end, out_data.frame_end));
        end else begin
          want = pending_results.pop_front();
          if (out_data.pixel_out !== want.pixel_out || out_data.row_end !== want.row_end ||
              out_data.frame_end !== want.frame_end)
            note_mismatch($sformatf({"result mismatch: expected pixel %0d row_end %0b ",
                                     "frame_end %0b, got pixel %0d row_end %0b frame_end %0b"},
                                    want.pixel_out, want.row_end, want.frame_end,
                                    out_data.pixel_out, out_data.row_end,
                                    out_data.frame_end));
        end
      end
    end
    awaited_count  <= pending_results.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== test/neighbor_mean_3x3_filter_test.sv =====
// Top of the 3x3 neighbor mean filter testbench: clock, reset, stimulus and verdict.
// Depends on nm3_pkg, the filter RTL and neighbor_mean_3x3_checker.
`timescale 1ns / 1ps

module neighbor_mean_3x3_filter_test;
  import nm3_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int NOISE_PCT     = 4;
  localparam int PHASE_ITEMS   = 530;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = CFG_ROW_ELEMENTS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               outstanding;
  int               mismatch_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  // Frame position as the block should see it; steers which command comes next.
  int pos_col      = 0;
  int pos_row      = 0;
  int pos_drain    = 0;
  bit pos_draining = 1'b0;
  int size_w       = ROW_ELEMENTS_RESET;
  int size_h       = FRAME_ROWS_RESET;
  int frames_done  = 0;
  int useful_items = 0;

  neighbor_mean_3x3_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  neighbor_mean_3x3_checker mean_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .awaited_count  (outstanding),
    .mismatch_count (mismatch_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** neighbor_mean_3x3_filter: FAILED **");
      $finish;
    end
  end

  function automatic int fit_size(input int raw, input int hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void advance_position(input logic cmd);
    if (cmd == CMD_DRAIN) begin
      if (pos_draining) begin
        if (pos_drain >= size_w - 1) begin
          pos_draining = 1'b0;
          pos_drain    = 0;
          frames_done++;
        end else begin
          pos_drain++;
        end
      end
    end else if (!pos_draining) begin
      if (pos_col >= size_w - 1) begin
        pos_col = 0;
        if (pos_row + 1 >= size_h) begin
          pos_row      = 0;
          pos_draining = 1'b1;
          pos_drain    = 0;
        end else begin
          pos_row++;
        end
      end else begin
        pos_col++;
      end
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [PIX_W-1:0] px);
    // Drains outside the last-row phase and pixels inside it are dropped by the block.
    if ((cmd == CMD_DRAIN) == pos_draining)
      useful_items++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, pixel_in: px};
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    advance_position(cmd);
  endtask

  task automatic next_item();
    logic             cmd;
    logic [PIX_W-1:0] px;
    cmd = pos_draining ? CMD_DRAIN : CMD_PIXEL;
    if ($urandom_range(99) < NOISE_PCT)
      cmd = (cmd == CMD_DRAIN) ? CMD_PIXEL : CMD_DRAIN;
    case ($urandom_range(7))
      0:       px = '0;
      1:       px = '1;
      default: px = PIX_W'($urandom);
    endcase
    send_item(cmd, px);
  endtask

  task automatic run_frames(input int count);
    int goal;
    goal = frames_done + count;
    while (frames_done < goal)
      next_item();
  endtask

  task automatic run_to(input int row, input int col);
    while (!(pos_row == row && pos_col == col && !pos_draining))
      next_item();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic reconfigure(input int w_raw, input int h_raw);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_ELEMENTS;
    cfg_wdata <= CFG_W'(w_raw);
    @(posedge clk);
    cfg_index <= CFG_FRAME_ROWS;
    cfg_wdata <= CFG_W'(h_raw);
    @(posedge clk);
    cfg_we <= 1'b0;
    size_w = fit_size(w_raw, MAX_ROW_ELEMENTS);
    size_h = fit_size(h_raw, MAX_ROWS);
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_DRAIN, '1);
    // Sizes below the minimum clamp to a 3x3 frame with a single interior element.
    reconfigure(2, 0);
    for (int i = 0; i < 9; i++)
      send_item(CMD_PIXEL, (i == 4) ? 8'd0 : 8'd255);
    send_item(CMD_PIXEL, 8'h5a);
    repeat (3) send_item(CMD_DRAIN, 8'h00);

    // Neighbor sums of 4 and 12 land exactly halfway and round to the even neighbor.
    reconfigure(4, 3);
    for (int i = 0; i < 12; i++)
      send_item(CMD_PIXEL, (i == 0) ? 8'd4 : (i == 3) ? 8'd12 : 8'd0);
    repeat (4) send_item(CMD_DRAIN, 8'hff);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 15 : (p == 1) ? 79 : 0;
      recv_idle_pct = (p == 0) ? 79 : (p == 1) ? 15 : 0;
      phase_start   = useful_items;

      // Shrink the row mid-frame; the current row then ends on its next element.
      reconfigure($urandom_range(8, 11), 6);
      run_to(2, 5);
      reconfigure($urandom_range(5), $urandom_range(7));
      run_frames(1);

      if (p == 2) begin
        reconfigure(3, 4095);
        run_to(6, 0);
        reconfigure(3, 1);
        run_frames(1);
        // A row length above the maximum clamps to the widest row; the first row is
        // cut short well before its end to keep the run brief.
        reconfigure(4095, 3);
        run_to(0, 40);
        reconfigure(3, 3);
        run_frames(1);
      end

      while (useful_items - phase_start < PHASE_ITEMS) begin
        reconfigure(($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12),
                    ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8));
        run_frames($urandom_range(1, 3));
      end
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0)
      $display("** neighbor_mean_3x3_filter: PASSED **");
    else
      $display("** neighbor_mean_3x3_filter: FAILED **");
    $finish;
  end

endmodule
